// ----- design/lrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lrsp_pkg
// shared types and constants of the load record stream parser
// ----------------------------------------------------------------------------
package lrsp_pkg;

   // result kinds
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_DONE_OK = 2'd2;
   localparam logic [1:0] KIND_DONE_ER = 2'd3;

   // record types and limits
   localparam logic [7:0] REC_EOF      = 8'd0;
   localparam logic [7:0] REC_LOAD     = 8'd1;
   localparam logic [7:0] REC_XFER     = 8'd2;
   localparam logic [7:0] MAX_REC_TYPE = 8'h1F;
   localparam logic [7:0] XFER_LEN     = 8'd2;
   localparam logic [7:0] ADDR_BYTES   = 8'd2;
   // a length byte of zero means 256, less the two address bytes
   localparam logic [7:0] LONG_LOAD_REMAIN = 8'd254;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN,
      PH_ALO,
      PH_AHI,
      PH_DATA,
      PH_SKIP
   } phase_type;

   // one queue entry: a result and whether a finished-ok result follows it
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic        add_done;
   } entry_type;

endpackage

// ----- design/lrsp_front.sv -----
// ----------------------------------------------------------------------------
// lrsp_front
// record parser: takes one byte a cycle while the queue is not full and queues the results it causes
// ----------------------------------------------------------------------------
module lrsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                q_full,
   output logic                q_push,
   output lrsp_pkg::entry_type q_entry
);
   import lrsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  remain_ff, remain_in;
   logic [15:0] cur_addr_ff, cur_addr_in;
   logic [7:0]  addr_lo_ff, addr_lo_in;
   logic [7:0]  rec_type_ff, rec_type_in;
   logic        finished_ff, finished_in;

   logic        accept;
   logic        res_valid;
   logic [1:0]  res_kind;
   logic [15:0] res_addr;
   logic [7:0]  res_data;
   logic        fin;
   logic [7:0]  b;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign b          = req_tdata;

   always_comb begin
      phase_in    = phase_ff;
      remain_in   = remain_ff;
      cur_addr_in = cur_addr_ff;
      addr_lo_in  = addr_lo_ff;
      rec_type_in = rec_type_ff;
      res_valid   = 1'b0;
      res_kind    = KIND_WRITE;
      res_addr    = 16'd0;
      res_data    = 8'd0;
      fin         = finished_ff;
      if (!finished_ff) begin
         case (phase_ff)
            PH_IDLE: begin
               rec_type_in = b;
               if (b > MAX_REC_TYPE) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_DONE_ER;
                  fin       = 1'b1;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (rec_type_ff == REC_LOAD) begin
                  if (b == 8'd1) begin
                     res_valid = 1'b1;
                     res_kind  = KIND_DONE_ER;
                     fin       = 1'b1;
                     phase_in  = PH_IDLE;
                  end else begin
                     remain_in = (b == 8'd0) ? LONG_LOAD_REMAIN : b - ADDR_BYTES;
                     phase_in  = PH_ALO;
                  end
               end else if (rec_type_ff == REC_XFER) begin
                  if (b != XFER_LEN) begin
                     res_valid = 1'b1;
                     res_kind  = KIND_DONE_ER;
                     fin       = 1'b1;
                     phase_in  = PH_IDLE;
                  end else begin
                     phase_in = PH_ALO;
                  end
               end else if (rec_type_ff == REC_EOF && b == 8'd0) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_DONE_OK;
                  fin       = 1'b1;
                  phase_in  = PH_IDLE;
               end else if (b == 8'd0) begin
                  phase_in = PH_IDLE;
               end else begin
                  remain_in = b;
                  phase_in  = PH_SKIP;
               end
            end
            PH_ALO: begin
               addr_lo_in = b;
               phase_in   = PH_AHI;
            end
            PH_AHI: begin
               if (rec_type_ff == REC_XFER) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_ENTRY;
                  res_addr  = {b, addr_lo_ff};
                  phase_in  = PH_IDLE;
               end else begin
                  cur_addr_in = {b, addr_lo_ff};
                  phase_in    = (remain_ff != 8'd0) ? PH_DATA : PH_IDLE;
               end
            end
            PH_DATA: begin
               res_valid   = 1'b1;
               res_kind    = KIND_WRITE;
               res_addr    = cur_addr_ff;
               res_data    = b;
               cur_addr_in = cur_addr_ff + 16'd1;
               remain_in   = remain_ff - 8'd1;
               if (remain_ff == 8'd1) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_SKIP: begin
               remain_in = remain_ff - 8'd1;
               if (remain_ff == 8'd1) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      finished_in = fin;
      // last byte of the image: back to reset state
      if (req_tlast) begin
         phase_in    = PH_IDLE;
         remain_in   = 8'd0;
         cur_addr_in = 16'd0;
         addr_lo_in  = 8'd0;
         rec_type_in = 8'd0;
         finished_in = 1'b0;
      end
   end

   always_comb begin
      q_push = accept && (res_valid || (req_tlast && !fin));
      if (res_valid) begin
         q_entry.kind     = res_kind;
         q_entry.addr     = res_addr;
         q_entry.data     = res_data;
         q_entry.add_done = req_tlast && !fin;
      end else begin
         q_entry.kind     = KIND_DONE_OK;
         q_entry.addr     = 16'd0;
         q_entry.data     = 8'd0;
         q_entry.add_done = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         remain_ff   <= 8'd0;
         cur_addr_ff <= 16'd0;
         addr_lo_ff  <= 8'd0;
         rec_type_ff <= 8'd0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         remain_ff   <= remain_in;
         cur_addr_ff <= cur_addr_in;
         addr_lo_ff  <= addr_lo_in;
         rec_type_ff <= rec_type_in;
         finished_ff <= finished_in;
      end
   end

endmodule

// ----- design/lrsp_queue.sv -----
// ----------------------------------------------------------------------------
// lrsp_queue
// small register fifo between parser and result stage
// ----------------------------------------------------------------------------
module lrsp_queue #(
   parameter int unsigned Depth = lrsp_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lrsp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output lrsp_pkg::entry_type pop_entry,
   output logic                empty
);
   import lrsp_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(Depth);

   entry_type           slots_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == FullCount);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/lrsp_back.sv -----
// ----------------------------------------------------------------------------
// lrsp_back
// result stage: expands queue entries into one or two result transfers
// ----------------------------------------------------------------------------
module lrsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  lrsp_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import lrsp_pkg::*;

   logic        valid_ff;
   logic        pend_done_ff;
   logic [1:0]  kind_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;
   logic        last_ff;
   logic        load;

   assign load  = !valid_ff || rsp_tready;
   assign q_pop = load && !pend_done_ff && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         pend_done_ff <= 1'b0;
      end else if (load) begin
         if (pend_done_ff) begin
            valid_ff     <= 1'b1;
            pend_done_ff <= 1'b0;
         end else begin
            valid_ff     <= !q_empty;
            pend_done_ff <= !q_empty && q_entry.add_done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (pend_done_ff) begin
            kind_ff <= KIND_DONE_OK;
            addr_ff <= 16'd0;
            data_ff <= 8'd0;
            last_ff <= 1'b1;
         end else begin
            kind_ff <= q_entry.kind;
            addr_ff <= q_entry.addr;
            data_ff <= q_entry.data;
            last_ff <= !q_entry.add_done;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff, addr_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- design/load_record_stream_parser.sv -----
// ----------------------------------------------------------------------------
// load_record_stream_parser
// parses a load-module image into memory writes, entry address and finish
// ----------------------------------------------------------------------------
// usage:
//   req channel carries the image one byte per transfer; req_tlast marks the
//   final byte of the image and returns the parser to idle afterwards
//   rsp channel carries results; rsp_tuser holds the kind: memory write
//   (kind 0), entry address (kind 1), finished ok (kind 2) or finished with
//   error (kind 3); rsp_tlast is set on the last result caused by one input byte
//   a byte is parsed in the cycle it is accepted; its first result passes
//   through the queue, then the output register, before it appears on rsp
//   throughput is one byte per cycle while the queue is not full; a last byte
//   that gives a result and also closes the file yields two results and
//   occupies the output register for both of them
//   the four-entry queue lets the parser run ahead while rsp is stalled;
//   req_tready drops only when that queue is full
//   reset (synchronous, active high) clears parser state, queue and output
//   register; no clearing pass is needed
// ----------------------------------------------------------------------------
module load_record_stream_parser #(
   parameter int unsigned QueueDepth = lrsp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // image input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] image_byte
   input  logic        req_tlast,   // last_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] target_address, [23:16] write_data
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // run_end
);
   import lrsp_pkg::*;

   entry_type push_entry;
   entry_type pop_entry;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;

   // front: parse state machine, one byte per transfer
   lrsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   // decoupling queue of pending results
   lrsp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   // back: output register, adds the trailing finish when asked
   lrsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/tb_load_record_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_load_record_stream_parser
// self-checking bench for the load record stream parser
// ----------------------------------------------------------------------------
// a directed table walks the record kinds and the error paths first, then
// random load-module images follow. Most images are well formed, with random
// record content. Some end in a bad record, some are cut short, and some are
// plain noise. Each accepted byte goes through a local parser model that
// queues the results it should cause. Each accepted result is compared field
// by field with the oldest queued one. Both sides idle at random, and the
// result side holds off once for a long stretch so that the input side stalls.
// ----------------------------------------------------------------------------
module tb_load_record_stream_parser;
   import lrsp_pkg::*;

   localparam int IMAGE_BYTES = 1750;   // stop sending random images past this
   localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES = 20;    // settle time after the last result
   localparam int PRESSURE_AFTER = 200; // results seen before the long hold-off
   localparam int PRESSURE_CYCLES = 300;

   // one result as it travels on rsp, unpacked
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic        run_end;
   } load_result_type;

   // one row of the directed table; typed rows carry their single result
   typedef struct packed {
      logic [7:0]  image_byte;
      logic        last;
      logic        typed;
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
   } directed_row_type;

   localparam int N_DIRECTED = 30;
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // type above the limit, also the last byte: error and nothing more
      '{8'h20, 1'b1, 1'b1, KIND_DONE_ER, 16'h0000, 8'h00},
      // load record with length one
      '{8'h01, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h01, 1'b1, 1'b1, KIND_DONE_ER, 16'h0000, 8'h00},
      // transfer record with a bad length
      '{8'h02, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h03, 1'b1, 1'b1, KIND_DONE_ER, 16'h0000, 8'h00},
      // load of three bytes at fffe, address wraps to zero
      '{8'h01, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h05, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'hFE, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'hFF, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h00, 1'b0, 1'b1, KIND_WRITE,   16'hFFFE, 8'h00},
      '{8'hFF, 1'b0, 1'b1, KIND_WRITE,   16'hFFFF, 8'hFF},
      '{8'hA5, 1'b0, 1'b1, KIND_WRITE,   16'h0000, 8'hA5},
      // highest skip type with a zero length
      '{8'h1F, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      // empty load record
      '{8'h01, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h02, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h34, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h12, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      // entry address
      '{8'h02, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h02, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'hCD, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'hAB, 1'b0, 1'b1, KIND_ENTRY,   16'hABCD, 8'h00},
      // end-of-file record, then an ignored last byte
      '{8'h00, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h00, 1'b0, 1'b1, KIND_DONE_OK, 16'h0000, 8'h00},
      '{8'hC3, 1'b1, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      // length zero means 256; cut short on its first data byte
      '{8'h01, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h80, 1'b0, 1'b0, KIND_WRITE,   16'h0000, 8'h00},
      '{8'h3C, 1'b1, 1'b0, KIND_WRITE,   16'h0000, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] image_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [15:0] target_address, [23:16] write_data
   logic [1:0]  rsp_tuser;   // [1:0] kind
   logic        rsp_tlast;   // run_end

   // results the parser still owes, oldest first
   load_result_type load_results_q[$];
   // results caused by the byte just accepted
   load_result_type step_res [2];
   int           step_cnt;

   // local copy of the parser state
   phase_type    img_phase;
   logic [8:0]   img_remaining;
   logic [15:0]  img_addr;
   logic [7:0]   img_addr_lo;
   logic [7:0]   img_rec_type;
   logic         img_done;

   logic [7:0]   image_q[$];   // random image under construction
   int           bytes_sent;
   int           results_seen;
   int           mismatch_count;
   int           idle_cycles;
   logic         sender_streaming;
   logic         rsp_streaming;
   logic         pressure_done;

   load_record_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------
   task automatic clear_parser();
      img_phase     = PH_IDLE;
      img_remaining = '0;
      img_addr      = '0;
      img_addr_lo   = '0;
      img_rec_type  = '0;
      img_done      = 1'b0;
   endtask

   task automatic emit_result(input logic [1:0] k, input logic [15:0] a,
                              input logic [7:0] d);
      step_res[step_cnt] = '{kind: k, addr: a, data: d, run_end: 1'b0};
      step_cnt++;
   endtask

   // a finish result also stops parsing until the last byte
   task automatic close_file(input logic [1:0] k);
      img_done  = 1'b1;
      img_phase = PH_IDLE;
      emit_result(k, 16'h0000, 8'h00);
   endtask

   task automatic parse_image_byte(input logic [7:0] b, input logic last);
      logic [8:0] load_len;
      step_cnt = 0;
      if (!img_done) begin
         case (img_phase)
            PH_IDLE: begin
               img_rec_type = b;
               if (b > MAX_REC_TYPE) close_file(KIND_DONE_ER);
               else img_phase = PH_LEN;
            end
            PH_LEN: begin
               if (img_rec_type == REC_LOAD) begin
                  // length counts the two address bytes, zero means 256
                  load_len = (b == 8'h00) ? 9'd256 : {1'b0, b};
                  if (load_len < {1'b0, ADDR_BYTES}) begin
                     close_file(KIND_DONE_ER);
                  end else begin
                     img_remaining = load_len - {1'b0, ADDR_BYTES};
                     img_phase     = PH_ALO;
                  end
               end else if (img_rec_type == REC_XFER) begin
                  if (b != XFER_LEN) close_file(KIND_DONE_ER);
                  else img_phase = PH_ALO;
               end else if (img_rec_type == REC_EOF && b == 8'h00) begin
                  close_file(KIND_DONE_OK);
               end else if (b == 8'h00) begin
                  img_phase = PH_IDLE;
               end else begin
                  img_remaining = {1'b0, b};
                  img_phase     = PH_SKIP;
               end
            end
            PH_ALO: begin
               img_addr_lo = b;
               img_phase   = PH_AHI;
            end
            PH_AHI: begin
               if (img_rec_type == REC_XFER) begin
                  emit_result(KIND_ENTRY, {b, img_addr_lo}, 8'h00);
                  img_phase = PH_IDLE;
               end else begin
                  img_addr  = {b, img_addr_lo};
                  img_phase = (img_remaining != 0) ? PH_DATA : PH_IDLE;
               end
            end
            PH_DATA: begin
               emit_result(KIND_WRITE, img_addr, b);
               img_addr = img_addr + 16'd1;
               if (img_remaining != 0) img_remaining = img_remaining - 9'd1;
               if (img_remaining == 0) img_phase = PH_IDLE;
            end
            PH_SKIP: begin
               if (img_remaining != 0) img_remaining = img_remaining - 9'd1;
               if (img_remaining == 0) img_phase = PH_IDLE;
            end
            default: img_phase = PH_IDLE;
         endcase
      end
      // last byte: close the file if still open, then back to idle
      if (last) begin
         if (!img_done) emit_result(KIND_DONE_OK, 16'h0000, 8'h00);
         clear_parser();
      end
      if (step_cnt > 0) step_res[step_cnt - 1].run_end = 1'b1;
   endtask

   // mostly short gaps, a few long ones, none while streaming
   function automatic int pick_idle(input logic streaming);
      int r;
      r = $urandom_range(0, 99);
      if (streaming || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------------
   // image byte sender; entered and left at a falling edge
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic use_typed, input load_result_type typed_res);
      int gap;
      gap = pick_idle(sender_streaming);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      // transfer accepted at this edge: update the model
      parse_image_byte(b, last);
      if (use_typed) begin
         load_results_q.push_back(typed_res);
      end else begin
         for (int i = 0; i < step_cnt; i++) load_results_q.push_back(step_res[i]);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   // one random image: a few records, then an ending of some kind
   task automatic send_random_image();
      int n_rec;
      int sel;
      int len;
      logic [7:0] rtype;
      image_q.delete();
      sender_streaming = ($urandom_range(0, 3) == 0);
      n_rec = $urandom_range(1, 6);
      for (int i = 0; i < n_rec; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            // load record; mostly short, rarely the longest ones
            sel = $urandom_range(0, 99);
            if (sel < 2) len = 256;
            else if (sel < 4) len = 255;
            else len = $urandom_range(2, 12);
            image_q.push_back(REC_LOAD);
            image_q.push_back(len[7:0]);
            // now and then start just below the top to force a wrap
            if ($urandom_range(0, 7) == 0) begin
               image_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
               image_q.push_back(8'hFF);
            end else begin
               image_q.push_back(8'($urandom_range(0, 255)));
               image_q.push_back(8'($urandom_range(0, 255)));
            end
            repeat (len - 2) image_q.push_back(8'($urandom_range(0, 255)));
         end else if (sel < 65) begin
            image_q.push_back(REC_XFER);
            image_q.push_back(XFER_LEN);
            image_q.push_back(8'($urandom_range(0, 255)));
            image_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            // skipped record: type 0 or 3..1f
            rtype = 8'($urandom_range(0, 29));
            if (rtype != 8'h00) rtype = rtype + 8'd2;
            len = $urandom_range(0, 6);
            if (rtype == REC_EOF && len == 0) len = 1;
            image_q.push_back(rtype);
            image_q.push_back(len[7:0]);
            repeat (len) image_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         // proper end-of-file record, maybe with trailing junk
         image_q.push_back(REC_EOF);
         image_q.push_back(8'h00);
         repeat ($urandom_range(0, 3)) image_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 75) begin
         // cut short somewhere near the end
         repeat ($urandom_range(0, 3)) if (image_q.size() > 1) void'(image_q.pop_back());
      end else if (sel < 90) begin
         // broken record
         case ($urandom_range(0, 2))
            0: image_q.push_back(8'($urandom_range(32, 255)));
            1: begin
               image_q.push_back(REC_LOAD);
               image_q.push_back(8'h01);
            end
            default: begin
               image_q.push_back(REC_XFER);
               rtype = 8'($urandom_range(0, 255));
               if (rtype == XFER_LEN) rtype = 8'h03;
               image_q.push_back(rtype);
            end
         endcase
         repeat ($urandom_range(0, 3)) image_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         // plain noise in place of the whole image
         image_q.delete();
         repeat ($urandom_range(1, 8)) image_q.push_back(8'($urandom_range(0, 255)));
      end
      foreach (image_q[i]) send_byte(image_q[i], i == image_q.size() - 1, 1'b0, '0);
   endtask

   task automatic report_mismatch(input string field, input int unsigned want_v,
                                  input int unsigned got_v);
      mismatch_count++;
      $display("mismatch at %0t: %s expected %0h got %0h",
               $time, field, want_v, got_v);
   endtask

   // ---------------------------------------------------------------------
   // result sink: random hold-offs, one long one to back up the input
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      int hold;
      rsp_tready    = 1'b0;
      rsp_streaming = 1'b0;
      pressure_done = 1'b0;
      @(negedge clock);
      forever begin
         if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(negedge clock);
         end else begin
            hold = pick_idle(rsp_streaming);
            if (hold > 0) begin
               rsp_tready <= 1'b0;
               repeat (hold) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) rsp_streaming = !rsp_streaming;
      end
   end

   // ---------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      load_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (load_results_q.size() == 0) begin
            report_mismatch("result with none pending", 0, 32'(rsp_tdata));
         end else begin
            want = load_results_q.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", 32'(want.kind), 32'(rsp_tuser));
            if (rsp_tdata[15:0] !== want.addr)
               report_mismatch("target_address", 32'(want.addr), 32'(rsp_tdata[15:0]));
            if (rsp_tdata[23:16] !== want.data)
               report_mismatch("write_data", 32'(want.data), 32'(rsp_tdata[23:16]));
            if (rsp_tlast !== want.run_end)
               report_mismatch("run_end", 32'(want.run_end), 32'(rsp_tlast));
         end
      end
   end

   // watchdog: too long without a transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      load_result_type typed_res;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = 8'h00;
      req_tlast        = 1'b0;
      sender_streaming = 1'b0;
      bytes_sent       = 0;
      results_seen     = 0;
      mismatch_count   = 0;
      idle_cycles      = 0;
      clear_parser();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         typed_res = '{kind: DIRECTED_ROWS[i].kind, addr: DIRECTED_ROWS[i].addr,
                       data: DIRECTED_ROWS[i].data, run_end: 1'b1};
         send_byte(DIRECTED_ROWS[i].image_byte, DIRECTED_ROWS[i].last,
                   DIRECTED_ROWS[i].typed, typed_res);
      end

      // random images
      while (bytes_sent < IMAGE_BYTES) send_random_image();
      req_tvalid <= 1'b0;

      // drain, then let the block settle
      while (load_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && load_results_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
